FILE: sv/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Flywheel speed controller package
// Field widths, fixed-point constants, register indexes and the sequencer
// states shared by the controller and its serial arithmetic units.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int VELOCITY_W   = 14;
   localparam int TARGET_RPM_W = 13;
   localparam int DRIVE_W      = 15;
   localparam int SPEED_W      = 18;
   localparam int GAIN_W       = 24;
   localparam int MARGIN_W     = 17;
   localparam int TOP_RPM_W    = 13;
   localparam int ERROR_SUM_W  = 32;

   localparam int Q16_SHIFT    = 16;
   localparam int Q16_MAX      = 131071;
   localparam int NORM_W       = VELOCITY_W + Q16_SHIFT;
   localparam int NORM_Q_W     = SPEED_W - 1;

   localparam int SMOOTH_W       = SPEED_W + 3;
   localparam int SMOOTH_DIV_W   = SMOOTH_W - 1;
   localparam int SMOOTH_DIVISOR = 5;
   localparam int SMOOTH_DVSR_W  = 3;
   localparam int SMOOTH_ROUND   = 2;

   localparam int RAW_ERR_W = SPEED_W + 2;

   localparam int PROD_V_W    = GAIN_W + NORM_Q_W;
   localparam int PROD_I_W    = GAIN_W + ERROR_SUM_W;
   localparam int ACC_W       = PROD_I_W + 1;
   localparam int ACC_CNT_W   = $clog2(ACC_W);
   localparam int GAIN_SHIFT  = 24;
   localparam int DRIVE_LIMIT_MV = 12000;

   localparam logic signed [SPEED_W-1:0]   SPEED_MAX = SPEED_W'(Q16_MAX);
   localparam logic signed [SPEED_W-1:0]   SPEED_MIN = -SPEED_MAX;
   localparam logic signed [RAW_ERR_W-1:0] RAW_MAX   = RAW_ERR_W'(Q16_MAX);
   localparam logic signed [RAW_ERR_W-1:0] RAW_MIN   = -RAW_MAX;
   localparam logic signed [DRIVE_W-1:0]   DRIVE_MAX = DRIVE_W'(DRIVE_LIMIT_MV);
   localparam logic signed [DRIVE_W-1:0]   DRIVE_MIN = -DRIVE_MAX;
   localparam logic signed [ACC_W-1:0]     ACC_LIMIT =
      ACC_W'(DRIVE_LIMIT_MV) <<< GAIN_SHIFT;
   localparam logic signed [ACC_W-1:0]     ACC_LIMIT_NEG = -ACC_LIMIT;
   localparam logic signed [ERROR_SUM_W-1:0] ERROR_SUM_MAX =
      {1'b0, {(ERROR_SUM_W-1){1'b1}}};
   localparam logic signed [ERROR_SUM_W-1:0] ERROR_SUM_MIN =
      {1'b1, {(ERROR_SUM_W-1){1'b0}}};

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = GAIN_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDFORWARD_GAIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROPORTIONAL_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANG_BANG_MARGIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_TOP_RPM     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLYWHEEL_TOP_RPM  = 3'd5;

   localparam logic [MARGIN_W-1:0]  MARGIN_RESET       = 17'd6554;
   localparam logic [TOP_RPM_W-1:0] MOTOR_TOP_RESET    = 13'd600;
   localparam logic [TOP_RPM_W-1:0] FLYWHEEL_TOP_RESET = 13'd3600;

   localparam int REQ_FIELDS_W = VELOCITY_W + TARGET_RPM_W;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_FIELDS_W = DRIVE_W + SPEED_W;
   localparam int RSP_TDATA_W  = 40;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM_WAIT,
      ST_SMOOTH_GO,
      ST_SMOOTH_WAIT,
      ST_ERROR,
      ST_INTEG,
      ST_HALVE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_ADD,
      ST_FINAL,
      ST_PUSH
   } state_type;

endpackage

FILE: sv/fsc_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned quotient of a dividend by a divisor, one quotient bit per cycle.
// The remainder path is only as wide as the divisor.
// ----------------------------------------------------------------------------
module fsc_div #(
   parameter int DIVIDEND_W = 30,
   parameter int DIVISOR_W  = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);
   import fsc_pkg::*;

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DIVIDEND_W - 1);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

FILE: sv/fsc_mul.sv
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Unsigned product, one multiplier bit per cycle. The adder is one bit wider
// than the multiplicand and the low product bits shift out to the right.
// ----------------------------------------------------------------------------
module fsc_mul #(
   parameter int A_W = 24,
   parameter int B_W = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     multiplicand,
   input  logic [B_W-1:0]     multiplier,
   output logic               busy,
   output logic [A_W+B_W-1:0] product
);
   import fsc_pkg::*;

   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [A_W-1:0]     mcand_ff, mcand_in;
   logic [A_W:0]       upper;

   assign upper = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(B_W - 1);
         prod_in  = {{A_W{1'b0}}, multiplier};
         mcand_in = multiplicand;
      end else if (busy_ff) begin
         prod_in = {upper, prod_ff[B_W-1:1]};
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign busy    = busy_ff;
   assign product = prod_ff;

endmodule

FILE: sv/flywheel_speed_controller_unit.sv
// ----------------------------------------------------------------------------
// Flywheel speed controller
// Bang-bang plus feedforward and PI velocity loop in Q16 fixed point,
// computed with serial dividers, serial multipliers and a serial adder.
// ----------------------------------------------------------------------------
// One word is taken at a time. A word in the full-drive branch goes from the
// error step straight to the output, past the integral update, the gain
// products and the serial sum. The two normalizing divisions run side by
// side at one bit per cycle over 30 bits, the divide by five of the
// smoothing filter has a 20-bit dividend, the integral gain product a 32-bit
// multiplier, and the three gain products are summed one bit per cycle over
// 57 bits. A finished result sits in the output register, so the next word
// is accepted while the previous result still waits to be taken.
module flywheel_speed_controller_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [fsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // motor_velocity, target_rpm, zero fill
   input  logic [fsc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // drive_millivolts, filtered_speed, zero fill
   output logic [fsc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // full_drive
   output logic                             rsp_tuser
);
   import fsc_pkg::*;

   state_type state_ff, state_in;

   logic [GAIN_W-1:0]    kv_ff, kv_in;
   logic [GAIN_W-1:0]    kp_ff, kp_in;
   logic [GAIN_W-1:0]    ki_ff, ki_in;
   logic [MARGIN_W-1:0]  margin_ff, margin_in;
   logic [TOP_RPM_W-1:0] motor_top_ff, motor_top_in;
   logic [TOP_RPM_W-1:0] fly_top_ff, fly_top_in;

   logic                          vel_neg_ff, vel_neg_in;
   logic [NORM_Q_W-1:0]           target_ff, target_in;
   logic signed [SPEED_W-1:0]     speed_ff, speed_in;
   logic                          smooth_neg_ff, smooth_neg_in;
   logic signed [SPEED_W-1:0]     smoothed_ff, smoothed_in;
   logic signed [SPEED_W-1:0]     err_ff, err_in;
   logic                          halve_ff, halve_in;
   logic signed [ERROR_SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [SPEED_W-1:0]     prev_error_ff, prev_error_in;
   logic                          neg_p_ff, neg_p_in;
   logic                          neg_i_ff, neg_i_in;
   logic [PROD_V_W-1:0]           sh_v_ff, sh_v_in;
   logic [PROD_V_W-1:0]           sh_p_ff, sh_p_in;
   logic [PROD_I_W-1:0]           sh_i_ff, sh_i_in;
   logic [1:0]                    carry_ff, carry_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_CNT_W-1:0]          bit_count_ff, bit_count_in;
   logic signed [DRIVE_W-1:0]     result_drive_ff, result_drive_in;
   logic                          result_full_ff, result_full_in;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                      rsp_full_ff, rsp_full_in;

   logic norm_start, smooth_start, mul_start, push;
   logic tgt_busy, spd_busy, div5_busy, mul_v_busy, mul_p_busy, mul_i_busy;

   logic [VELOCITY_W-1:0]   req_velocity;
   logic [TARGET_RPM_W-1:0] req_target_rpm;
   logic [VELOCITY_W-1:0]   vel_mag;
   logic [NORM_W-1:0]       tgt_dividend, spd_dividend;
   logic [TOP_RPM_W-1:0]    motor_divisor, fly_divisor;
   logic [NORM_W-1:0]       tgt_quot, spd_quot;
   logic [NORM_Q_W-1:0]     tgt_sat, spd_mag;

   logic signed [SMOOTH_W-1:0] smooth_sum;
   logic [SMOOTH_W-1:0]        smooth_abs;
   logic [SMOOTH_DIV_W-1:0]    smooth_dividend;
   logic [SMOOTH_DIV_W-1:0]    div5_quot;
   logic [SPEED_W-1:0]         smooth_q;

   logic signed [RAW_ERR_W-1:0]   raw_error;
   logic                          raw_full;
   logic signed [SPEED_W-1:0]     err_sat;
   logic                          halve_cond;
   logic signed [ERROR_SUM_W:0]   sum_wide;
   logic signed [ERROR_SUM_W-1:0] sum_sat;
   logic signed [ERROR_SUM_W-1:0] halve_tmp;

   logic [SPEED_W-1:0]     err_abs;
   logic [ERROR_SUM_W-1:0] sum_mag;
   logic [PROD_V_W-1:0]    prod_v, prod_p;
   logic [PROD_I_W-1:0]    prod_i;

   logic                      bit_p, bit_i;
   logic [2:0]                add_total;
   logic signed [DRIVE_W-1:0] drive_trunc;

   assign req_velocity   = req_tdata[VELOCITY_W-1:0];
   assign req_target_rpm = req_tdata[REQ_FIELDS_W-1:VELOCITY_W];
   assign vel_mag = req_velocity[VELOCITY_W-1] ? (~req_velocity + 1'b1) : req_velocity;
   assign spd_dividend = {vel_mag, {Q16_SHIFT{1'b0}}};
   assign tgt_dividend = {1'b0, req_target_rpm, {Q16_SHIFT{1'b0}}};
   assign motor_divisor = (motor_top_ff == '0) ? TOP_RPM_W'(1) : motor_top_ff;
   assign fly_divisor   = (fly_top_ff == '0) ? TOP_RPM_W'(1) : fly_top_ff;

   assign tgt_sat = (|tgt_quot[NORM_W-1:NORM_Q_W]) ? '1 : tgt_quot[NORM_Q_W-1:0];
   assign spd_mag = (|spd_quot[NORM_W-1:NORM_Q_W]) ? '1 : spd_quot[NORM_Q_W-1:0];

   assign smooth_sum = {{(SMOOTH_W-SPEED_W){speed_ff[SPEED_W-1]}}, speed_ff}
                     + {smoothed_ff[SPEED_W-1], smoothed_ff, 2'b00};
   assign smooth_abs = smooth_sum[SMOOTH_W-1] ? (~smooth_sum + 1'b1) : smooth_sum;
   assign smooth_dividend = smooth_abs[SMOOTH_DIV_W-1:0] + SMOOTH_DIV_W'(SMOOTH_ROUND);
   assign smooth_q = div5_quot[SPEED_W-1:0];

   assign raw_error = $signed({{(RAW_ERR_W-NORM_Q_W){1'b0}}, target_ff})
                    - $signed({{(RAW_ERR_W-SPEED_W){smoothed_ff[SPEED_W-1]}}, smoothed_ff});
   assign raw_full = raw_error > $signed({{(RAW_ERR_W-MARGIN_W){1'b0}}, margin_ff});
   assign err_sat = (raw_error > RAW_MAX) ? SPEED_MAX :
                    (raw_error < RAW_MIN) ? SPEED_MIN : raw_error[SPEED_W-1:0];
   assign halve_cond = (!err_sat[SPEED_W-1] && (err_sat != '0))
                    && (prev_error_ff[SPEED_W-1] || (prev_error_ff == '0));

   assign sum_wide = {error_sum_ff[ERROR_SUM_W-1], error_sum_ff}
                   + {{(ERROR_SUM_W+1-SPEED_W){err_ff[SPEED_W-1]}}, err_ff};
   assign sum_sat = (sum_wide[ERROR_SUM_W] != sum_wide[ERROR_SUM_W-1]) ?
                    (sum_wide[ERROR_SUM_W] ? ERROR_SUM_MIN : ERROR_SUM_MAX) :
                    sum_wide[ERROR_SUM_W-1:0];
   assign halve_tmp = error_sum_ff
                    + {{(ERROR_SUM_W-1){1'b0}}, error_sum_ff[ERROR_SUM_W-1]};

   assign err_abs = err_ff[SPEED_W-1] ? (~err_ff + 1'b1) : err_ff;
   assign sum_mag = error_sum_ff[ERROR_SUM_W-1] ? (~error_sum_ff + 1'b1) : error_sum_ff;

   assign bit_p = sh_p_ff[0] ^ neg_p_ff;
   assign bit_i = sh_i_ff[0] ^ neg_i_ff;
   assign add_total = {2'b00, sh_v_ff[0]} + {2'b00, bit_p} + {2'b00, bit_i}
                    + {1'b0, carry_ff};

   assign drive_trunc = acc_ff[GAIN_SHIFT+DRIVE_W-1:GAIN_SHIFT]
                      + {{(DRIVE_W-1){1'b0}},
                         acc_ff[ACC_W-1] && (|acc_ff[GAIN_SHIFT-1:0])};

   fsc_div #(.DIVIDEND_W(NORM_W), .DIVISOR_W(TOP_RPM_W)) u_tgt_div (
      .clock(clock), .reset(reset), .start(norm_start),
      .dividend(tgt_dividend), .divisor(fly_divisor),
      .busy(tgt_busy), .quotient(tgt_quot)
   );

   fsc_div #(.DIVIDEND_W(NORM_W), .DIVISOR_W(TOP_RPM_W)) u_spd_div (
      .clock(clock), .reset(reset), .start(norm_start),
      .dividend(spd_dividend), .divisor(motor_divisor),
      .busy(spd_busy), .quotient(spd_quot)
   );

   fsc_div #(.DIVIDEND_W(SMOOTH_DIV_W), .DIVISOR_W(SMOOTH_DVSR_W)) u_div5 (
      .clock(clock), .reset(reset), .start(smooth_start),
      .dividend(smooth_dividend), .divisor(SMOOTH_DVSR_W'(SMOOTH_DIVISOR)),
      .busy(div5_busy), .quotient(div5_quot)
   );

   fsc_mul #(.A_W(GAIN_W), .B_W(NORM_Q_W)) u_mul_v (
      .clock(clock), .reset(reset), .start(mul_start),
      .multiplicand(kv_ff), .multiplier(target_ff),
      .busy(mul_v_busy), .product(prod_v)
   );

   fsc_mul #(.A_W(GAIN_W), .B_W(NORM_Q_W)) u_mul_p (
      .clock(clock), .reset(reset), .start(mul_start),
      .multiplicand(kp_ff), .multiplier(err_abs[NORM_Q_W-1:0]),
      .busy(mul_p_busy), .product(prod_p)
   );

   fsc_mul #(.A_W(GAIN_W), .B_W(ERROR_SUM_W)) u_mul_i (
      .clock(clock), .reset(reset), .start(mul_start),
      .multiplicand(ki_ff), .multiplier(sum_mag),
      .busy(mul_i_busy), .product(prod_i)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (!tgt_busy && !spd_busy) state_in = ST_SMOOTH_GO;
         end
         ST_SMOOTH_GO: state_in = ST_SMOOTH_WAIT;
         ST_SMOOTH_WAIT: begin
            if (!div5_busy) state_in = ST_ERROR;
         end
         ST_ERROR: state_in = raw_full ? ST_PUSH : ST_INTEG;
         ST_INTEG: state_in = ST_HALVE;
         ST_HALVE: state_in = ST_MUL_GO;
         ST_MUL_GO: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (!mul_v_busy && !mul_p_busy && !mul_i_busy) state_in = ST_ADD;
         end
         ST_ADD: begin
            if (bit_count_ff == ACC_CNT_W'(ACC_W - 1)) state_in = ST_FINAL;
         end
         ST_FINAL: state_in = ST_PUSH;
         ST_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      norm_start   = 1'b0;
      smooth_start = 1'b0;
      mul_start    = 1'b0;
      push         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            norm_start = req_tvalid;
         end
         ST_SMOOTH_GO: smooth_start = 1'b1;
         ST_MUL_GO:    mul_start    = 1'b1;
         ST_PUSH:      push = !rsp_tvalid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      kv_in           = kv_ff;
      kp_in           = kp_ff;
      ki_in           = ki_ff;
      margin_in       = margin_ff;
      motor_top_in    = motor_top_ff;
      fly_top_in      = fly_top_ff;
      vel_neg_in      = vel_neg_ff;
      target_in       = target_ff;
      speed_in        = speed_ff;
      smooth_neg_in   = smooth_neg_ff;
      smoothed_in     = smoothed_ff;
      err_in          = err_ff;
      halve_in        = halve_ff;
      error_sum_in    = error_sum_ff;
      prev_error_in   = prev_error_ff;
      neg_p_in        = neg_p_ff;
      neg_i_in        = neg_i_ff;
      sh_v_in         = sh_v_ff;
      sh_p_in         = sh_p_ff;
      sh_i_in         = sh_i_ff;
      carry_in        = carry_ff;
      acc_in          = acc_ff;
      bit_count_in    = bit_count_ff;
      result_drive_in = result_drive_ff;
      result_full_in  = result_full_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_drive_in    = rsp_drive_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_full_in     = rsp_full_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_FEEDFORWARD_GAIN:  kv_in = csr_write_data[GAIN_W-1:0];
            CSR_PROPORTIONAL_GAIN: kp_in = csr_write_data[GAIN_W-1:0];
            CSR_INTEGRAL_GAIN:     ki_in = csr_write_data[GAIN_W-1:0];
            CSR_BANG_BANG_MARGIN:  margin_in = csr_write_data[MARGIN_W-1:0];
            CSR_MOTOR_TOP_RPM:     motor_top_in = csr_write_data[TOP_RPM_W-1:0];
            CSR_FLYWHEEL_TOP_RPM:  fly_top_in = csr_write_data[TOP_RPM_W-1:0];
            default: begin
               kv_in = kv_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            vel_neg_in = req_velocity[VELOCITY_W-1];
         end
         ST_NORM_WAIT: begin
            target_in = tgt_sat;
            speed_in  = vel_neg_ff ? (SPEED_W'(0) - {1'b0, spd_mag}) : {1'b0, spd_mag};
         end
         ST_SMOOTH_GO: begin
            smooth_neg_in = smooth_sum[SMOOTH_W-1];
         end
         ST_SMOOTH_WAIT: begin
            smoothed_in = smooth_neg_ff ? (SPEED_W'(0) - smooth_q) : smooth_q;
         end
         ST_ERROR: begin
            err_in          = err_sat;
            halve_in        = halve_cond;
            result_drive_in = DRIVE_MAX;
            result_full_in  = raw_full;
         end
         ST_INTEG: begin
            error_sum_in  = sum_sat;
            prev_error_in = err_ff;
         end
         ST_HALVE: begin
            if (halve_ff) begin
               error_sum_in = {halve_tmp[ERROR_SUM_W-1], halve_tmp[ERROR_SUM_W-1:1]};
            end
         end
         ST_MUL_GO: begin
            neg_p_in = err_ff[SPEED_W-1];
            neg_i_in = error_sum_ff[ERROR_SUM_W-1];
         end
         ST_MUL_WAIT: begin
            sh_v_in      = prod_v;
            sh_p_in      = prod_p;
            sh_i_in      = prod_i;
            carry_in     = {1'b0, neg_p_ff} + {1'b0, neg_i_ff};
            bit_count_in = '0;
         end
         ST_ADD: begin
            acc_in       = {add_total[0], acc_ff[ACC_W-1:1]};
            carry_in     = add_total[2:1];
            sh_v_in      = {1'b0, sh_v_ff[PROD_V_W-1:1]};
            sh_p_in      = {1'b0, sh_p_ff[PROD_V_W-1:1]};
            sh_i_in      = {1'b0, sh_i_ff[PROD_I_W-1:1]};
            bit_count_in = bit_count_ff + 1'b1;
         end
         ST_FINAL: begin
            if (acc_ff > ACC_LIMIT) begin
               result_drive_in = DRIVE_MAX;
            end else if (acc_ff < ACC_LIMIT_NEG) begin
               result_drive_in = DRIVE_MIN;
            end else begin
               result_drive_in = drive_trunc;
            end
            result_full_in = 1'b0;
         end
         ST_PUSH: begin
            if (push) begin
               rsp_tvalid_in = 1'b1;
               rsp_drive_in  = result_drive_ff;
               rsp_speed_in  = smoothed_ff;
               rsp_full_in   = result_full_ff;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kv_ff         <= '0;
         kp_ff         <= '0;
         ki_ff         <= '0;
         margin_ff     <= MARGIN_RESET;
         motor_top_ff  <= MOTOR_TOP_RESET;
         fly_top_ff    <= FLYWHEEL_TOP_RESET;
         smoothed_ff   <= '0;
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kv_ff         <= kv_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         margin_ff     <= margin_in;
         motor_top_ff  <= motor_top_in;
         fly_top_ff    <= fly_top_in;
         smoothed_ff   <= smoothed_in;
         error_sum_ff  <= error_sum_in;
         prev_error_ff <= prev_error_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      vel_neg_ff      <= vel_neg_in;
      target_ff       <= target_in;
      speed_ff        <= speed_in;
      smooth_neg_ff   <= smooth_neg_in;
      err_ff          <= err_in;
      halve_ff        <= halve_in;
      neg_p_ff        <= neg_p_in;
      neg_i_ff        <= neg_i_in;
      sh_v_ff         <= sh_v_in;
      sh_p_ff         <= sh_p_in;
      sh_i_ff         <= sh_i_in;
      carry_ff        <= carry_in;
      acc_ff          <= acc_in;
      bit_count_ff    <= bit_count_in;
      result_drive_ff <= result_drive_in;
      result_full_ff  <= result_full_in;
      rsp_drive_ff    <= rsp_drive_in;
      rsp_speed_ff    <= rsp_speed_in;
      rsp_full_ff     <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}}, rsp_speed_ff, rsp_drive_ff};
   assign rsp_tuser  = rsp_full_ff;

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (tgt_busy && spd_busy))
      else $error("normalizing dividers did not start on an accepted word");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (!mul_v_busy && !mul_p_busy && !mul_i_busy))
      else $error("serial sum started before the gain products were done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> ((rsp_drive_ff <= DRIVE_MAX) && (rsp_drive_ff >= DRIVE_MIN)))
      else $error("drive voltage outside the clamp range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_full_ff) |-> (rsp_drive_ff == DRIVE_MAX))
      else $error("full drive flagged without full voltage");

endmodule

FILE: bench/flywheel_speed_controller_checker.sv
// ----------------------------------------------------------------------------
// Flywheel speed controller checker
// Watches the register port and both streams of the controller, keeps its
// own copy of the registers and the loop state, predicts the drive word for
// every accepted velocity word and compares each returned word with the
// oldest prediction.
// ----------------------------------------------------------------------------
module flywheel_speed_controller_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [fsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [fsc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [fsc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   output int                               mismatches,
   output int                               outstanding,
   output int                               checked,
   output int                               full_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import fsc_pkg::*;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive_mv;
      logic signed [SPEED_W-1:0] speed_q16;
      logic                      full_drive;
   } drive_result_type;

   drive_result_type pending_drives[$];
   drive_result_type want;

   longint ff_gain, p_gain, i_gain, margin, motor_top, fly_top;
   longint speed_state, sum_state, prev_error;

   logic signed [DRIVE_W-1:0] got_drive;
   logic signed [SPEED_W-1:0] got_speed;
   int fail_tally = 0;
   int checked_tally = 0;
   int full_tally = 0;

   function automatic longint limit_to(input longint value, input longint lo,
                                       input longint hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   function automatic longint to_q16(input longint value, input longint top);
      longint divisor;
      divisor = (top == 0) ? 1 : top;
      return limit_to((value <<< Q16_SHIFT) / divisor, -Q16_MAX, Q16_MAX);
   endfunction

   function automatic drive_result_type next_drive(input logic [REQ_TDATA_W-1:0] word);
      longint velocity, target, speed, blend, raw_error, err_q16, total;
      longint acc, acc_limit, drive;
      drive_result_type res;
      velocity = longint'($signed(word[VELOCITY_W-1:0]));
      target   = to_q16(longint'(word[VELOCITY_W +: TARGET_RPM_W]), fly_top);
      speed    = to_q16(velocity, motor_top);

      blend = speed + (SMOOTH_DIVISOR - 1) * speed_state;
      if (blend >= 0)
         blend = (blend + SMOOTH_ROUND) / SMOOTH_DIVISOR;
      else
         blend = -((-blend + SMOOTH_ROUND) / SMOOTH_DIVISOR);
      speed_state = limit_to(blend, -Q16_MAX, Q16_MAX);

      raw_error = target - speed_state;
      if (raw_error > margin) begin
         drive = DRIVE_LIMIT_MV;
         res.full_drive = 1'b1;
      end else begin
         err_q16 = limit_to(raw_error, -Q16_MAX, Q16_MAX);
         total = limit_to(sum_state + err_q16, longint'(ERROR_SUM_MIN),
                          longint'(ERROR_SUM_MAX));
         if (err_q16 > 0 && prev_error <= 0)
            total = total / 2;
         sum_state  = total;
         prev_error = err_q16;
         acc = ff_gain * target + p_gain * err_q16 + i_gain * sum_state;
         acc_limit = longint'(DRIVE_LIMIT_MV) <<< GAIN_SHIFT;
         acc = limit_to(acc, -acc_limit, acc_limit);
         drive = acc / (64'sd1 <<< GAIN_SHIFT);
         res.full_drive = 1'b0;
      end
      res.drive_mv  = DRIVE_W'(drive);
      res.speed_q16 = SPEED_W'(speed_state);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ff_gain     = 0;
         p_gain      = 0;
         i_gain      = 0;
         margin      = longint'(MARGIN_RESET);
         motor_top   = longint'(MOTOR_TOP_RESET);
         fly_top     = longint'(FLYWHEEL_TOP_RESET);
         speed_state = 0;
         sum_state   = 0;
         prev_error  = 0;
         pending_drives.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FEEDFORWARD_GAIN:  ff_gain   = longint'(csr_write_data[GAIN_W-1:0]);
               CSR_PROPORTIONAL_GAIN: p_gain    = longint'(csr_write_data[GAIN_W-1:0]);
               CSR_INTEGRAL_GAIN:     i_gain    = longint'(csr_write_data[GAIN_W-1:0]);
               CSR_BANG_BANG_MARGIN:  margin    = longint'(csr_write_data[MARGIN_W-1:0]);
               CSR_MOTOR_TOP_RPM:     motor_top = longint'(csr_write_data[TOP_RPM_W-1:0]);
               CSR_FLYWHEEL_TOP_RPM:  fly_top   = longint'(csr_write_data[TOP_RPM_W-1:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_drives.push_back(next_drive(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_drive = rsp_tdata[DRIVE_W-1:0];
            got_speed = rsp_tdata[DRIVE_W +: SPEED_W];
            if (pending_drives.size() == 0) begin
               fail_tally++;
               $display("%0t: unexpected word, expected none, got drive %0d speed %0d full %0b",
                        $time, got_drive, got_speed, rsp_tuser);
            end else begin
               want = pending_drives.pop_front();
               checked_tally++;
               if (rsp_tuser === 1'b1)
                  full_tally++;
               if (got_drive !== want.drive_mv) begin
                  fail_tally++;
                  $display("%0t: drive_millivolts expected %0d got %0d",
                           $time, want.drive_mv, got_drive);
               end
               if (got_speed !== want.speed_q16) begin
                  fail_tally++;
                  $display("%0t: filtered_speed expected %0d got %0d",
                           $time, want.speed_q16, got_speed);
               end
               if (rsp_tuser !== want.full_drive) begin
                  fail_tally++;
                  $display("%0t: full_drive expected %0b got %0b",
                           $time, want.full_drive, rsp_tuser);
               end
            end
         end
      end
      outstanding <= pending_drives.size();
      mismatches  <= fail_tally;
      checked     <= checked_tally;
      full_seen   <= full_tally;
   end

endmodule

FILE: bench/flywheel_speed_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Flywheel speed controller testbench
// Drives velocity and target words into the controller under random source
// gaps and sink stalls, reprograms the registers between phases while the
// controller is idle, and lets the checker judge every drive word.
// ----------------------------------------------------------------------------
module flywheel_speed_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fsc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_WORDS   = 150;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 1500;
   localparam int VELOCITY_MAX  = 8191;
   localparam int TARGET_MAX    = 8191;

   typedef enum int {SET_MODERATE, SET_WIDE, SET_CORNER} setting_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   int mismatches, outstanding, checked, full_seen;
   int words_sent = 0;
   int settings_applied = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int ff_gain, p_gain, i_gain, margin, motor_top, fly_top;
   setting_style_type style;

   flywheel_speed_controller_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

   flywheel_speed_controller_checker drive_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .checked          (checked),
      .full_seen        (full_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 31);
      end
   end

   task automatic send_word(input int velocity, input int target_rpm);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[VELOCITY_W-1:0] = VELOCITY_W'(velocity);
      word[VELOCITY_W +: TARGET_RPM_W] = TARGET_RPM_W'(target_rpm);
      if (!quiet && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 170)) @(posedge clock);
         else
            repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // With odd_writes set, narrow registers get garbage above their width and
   // the two unused indexes are written as well.
   task automatic apply_settings(input bit odd_writes);
      write_register(CSR_FEEDFORWARD_GAIN, CSR_DATA_W'(ff_gain));
      write_register(CSR_PROPORTIONAL_GAIN, CSR_DATA_W'(p_gain));
      write_register(CSR_INTEGRAL_GAIN, CSR_DATA_W'(i_gain));
      write_register(CSR_BANG_BANG_MARGIN,
                     CSR_DATA_W'(margin | (odd_writes ? ($urandom << MARGIN_W) : 0)));
      write_register(CSR_MOTOR_TOP_RPM,
                     CSR_DATA_W'(motor_top | (odd_writes ? ($urandom << TOP_RPM_W) : 0)));
      write_register(CSR_FLYWHEEL_TOP_RPM,
                     CSR_DATA_W'(fly_top | (odd_writes ? ($urandom << TOP_RPM_W) : 0)));
      if (odd_writes) begin
         write_register(CSR_SPARE_LO, CSR_DATA_W'($urandom));
         write_register(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      end
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic pick_settings(input setting_style_type kind);
      case (kind)
         SET_MODERATE: begin
            ff_gain   = $urandom_range(0, 1 << 22);
            p_gain    = $urandom_range(0, 1 << 21);
            i_gain    = $urandom_range(0, 1 << 16);
            margin    = $urandom_range(0, 20000);
            motor_top = $urandom_range(50, 2000);
            fly_top   = $urandom_range(200, 8191);
         end
         SET_WIDE: begin
            ff_gain   = $urandom_range(0, 16777215);
            p_gain    = $urandom_range(0, 16777215);
            i_gain    = $urandom_range(0, 16777215);
            margin    = $urandom_range(0, 131071);
            motor_top = $urandom_range(1, 8191);
            fly_top   = $urandom_range(1, 8191);
         end
         default: begin
            ff_gain   = $urandom_range(1) ? 16777215 : 0;
            p_gain    = $urandom_range(1) ? 16777215 : $urandom_range(0, 16777215);
            i_gain    = $urandom_range(1) ? 16777215 : 0;
            margin    = $urandom_range(1) ? 131071 : 0;
            motor_top = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 1 : 8191);
            fly_top   = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 1 : 8191);
         end
      endcase
   endtask

   // Most words come in runs with a steady target and a velocity near the
   // matching speed, so the filter settles and the error changes sign.
   task automatic run_random(input int count);
      int sent, run_len, target, base, span, velocity, m_eff, f_eff, pick;
      sent  = 0;
      m_eff = (motor_top == 0) ? 1 : motor_top;
      f_eff = (fly_top == 0) ? 1 : fly_top;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            run_len = $urandom_range(4, 30);
            if (run_len > count - sent)
               run_len = count - sent;
            target  = $urandom_range(0, (2 * f_eff > TARGET_MAX) ? TARGET_MAX : 2 * f_eff);
            base    = target * m_eff / f_eff;
            span    = m_eff / 16 + 1;
            repeat (run_len) begin
               velocity = base + int'($urandom_range(0, 2 * span)) - span;
               if (velocity > VELOCITY_MAX) velocity = VELOCITY_MAX;
               if (velocity < -VELOCITY_MAX) velocity = -VELOCITY_MAX;
               send_word(velocity, target);
            end
            sent += run_len;
         end else if (pick < 90) begin
            send_word(int'($urandom_range(0, 2 * VELOCITY_MAX)) - VELOCITY_MAX,
                      $urandom_range(0, TARGET_MAX));
            sent++;
         end else begin
            velocity = $urandom_range(2) == 0 ? -VELOCITY_MAX :
                       ($urandom_range(1) ? 0 : VELOCITY_MAX);
            send_word(velocity, $urandom_range(1) ? TARGET_MAX : 0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(0, 0);
      send_word(0, TARGET_MAX);
      send_word(VELOCITY_MAX, 0);
      send_word(-VELOCITY_MAX, 0);
      drain();

      ff_gain   = 3000000;
      p_gain    = 1000000;
      i_gain    = 20000;
      margin    = 6554;
      motor_top = 600;
      fly_top   = 3600;
      apply_settings(1'b0);
      repeat (6) send_word(300, 1800);
      repeat (3) send_word(330, 1800);
      repeat (3) send_word(270, 1800);
      drain();

      ff_gain   = 16777215;
      p_gain    = 16777215;
      i_gain    = 16777215;
      margin    = 131071;
      motor_top = 0;
      fly_top   = 0;
      apply_settings(1'b0);
      send_word(VELOCITY_MAX, TARGET_MAX);
      send_word(-VELOCITY_MAX, TARGET_MAX);
      send_word(-VELOCITY_MAX, 0);
      send_word(VELOCITY_MAX, 0);
      send_word(0, 1);
      send_word(1, 0);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = (phase == 3 || phase == 5) ? SET_WIDE :
                 (phase == 4) ? SET_CORNER : SET_MODERATE;
         pick_settings(style);
         apply_settings(phase == 3);
         quiet = (phase == 2);
         if (phase == 1)
            hold_request = 1'b1;
         run_random(PHASE_WORDS);
         drain();
      end
      quiet = 1'b0;

      $display("Covered %0d words over %0d register settings: directed extremes,",
               words_sent, settings_applied);
      $display("tracking runs, noise and corner words.");
      $display("Checked %0d drive words, %0d of them at full drive.", checked, full_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("flywheel_speed_controller_unit_tb: PASS");
      else
         $display("flywheel_speed_controller_unit_tb: FAIL");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("flywheel_speed_controller_unit_tb: FAIL");
      $finish;
   end

endmodule
